// ===== rtl/mhs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhs_pkg
// shared widths, codes and the controller/datapath command and status groups
// ----------------------------------------------------------------------------
package mhs_pkg;

	localparam int IDX_W       = 6;
	localparam int COEF_W      = 20;
	localparam int VAL_W       = 32;
	// a*x+b with a, b of 20 bits and x of 32 bits stays below 2^53
	localparam int PROD_W      = 53;
	localparam int TABLE_DEPTH = 64;

	localparam logic [VAL_W-1:0] RESET_MODULUS = 32'd1000003;

	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_ELEM = 1'b1;

	typedef struct packed {
		logic tbl_wr;
		logic elem_start;
		logic issue_en;
		logic out_rd;
		logic out_ld;
		logic clear_min;
	} cmd_t;

	typedef struct packed {
		logic issue_last;
		logic pipe_busy;
		logic out_free;
		logic out_last;
	} stat_t;

endpackage

// ===== rtl/mhs_mod_pipe.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhs_mod_pipe
// pipelined restoring remainder, one dividend bit per stage
// ----------------------------------------------------------------------------
module mhs_mod_pipe import mhs_pkg::*; #(
	parameter int TAG_W = 6
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [PROD_W-1:0] dividend,
	input  logic [VAL_W-1:0]  modulus,
	input  logic [TAG_W-1:0]  tag,
	output logic              out_valid,
	output logic [VAL_W-1:0]  remainder,
	output logic [TAG_W-1:0]  out_tag,
	output logic              busy
);

	logic              vld_s [1:PROD_W];
	logic [VAL_W-1:0]  rem_s [1:PROD_W];
	logic [PROD_W-1:0] div_s [1:PROD_W];
	logic [TAG_W-1:0]  tag_s [1:PROD_W];

	for (genvar i = 0; i < PROD_W; i++) begin : g_stage
		logic              cur_vld;
		logic [VAL_W-1:0]  cur_rem;
		logic [PROD_W-1:0] cur_div;
		logic [TAG_W-1:0]  cur_tag;
		logic [VAL_W:0]    trial;
		logic [VAL_W:0]    diff;

		if (i == 0) begin : g_first
			assign cur_vld = in_valid;
			assign cur_rem = '0;
			assign cur_div = dividend;
			assign cur_tag = tag;
		end else begin : g_next
			assign cur_vld = vld_s[i];
			assign cur_rem = rem_s[i];
			assign cur_div = div_s[i];
			assign cur_tag = tag_s[i];
		end

		// shift in the next dividend bit, subtract once if it reaches the modulus
		assign trial = {cur_rem, cur_div[PROD_W-1-i]};
		assign diff  = trial - {1'b0, modulus};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else begin
				vld_s[i+1] <= cur_vld;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[i+1] <= (trial >= {1'b0, modulus}) ? diff[VAL_W-1:0] : trial[VAL_W-1:0];
			div_s[i+1] <= cur_div;
			tag_s[i+1] <= cur_tag;
		end
	end

	always_comb begin
		busy = 1'b0;
		for (int j = 1; j <= PROD_W; j++) begin
			busy = busy | vld_s[j];
		end
	end

	assign out_valid = vld_s[PROD_W];
	assign remainder = rem_s[PROD_W];
	assign out_tag   = tag_s[PROD_W];

	a_rem_below_mod: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (remainder < modulus))
		else $error("remainder not reduced below modulus");

endmodule

// ===== rtl/mhs_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhs_datapath
// coefficient tables, multiply-add, modulo pipe, running minima, output word
// ----------------------------------------------------------------------------
module mhs_datapath import mhs_pkg::*; #(
	parameter int ACTIVE = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	output stat_t             status,
	input  logic              cfg_we,
	input  logic [VAL_W-1:0]  cfg_wdata,
	input  logic [IDX_W-1:0]  hash_index,
	input  logic [COEF_W-1:0] coeff_a,
	input  logic [COEF_W-1:0] coeff_b,
	input  logic [VAL_W-1:0]  element_value,
	input  logic              out_stall,
	output logic              out_valid,
	output logic [IDX_W-1:0]  signature_index,
	output logic [VAL_W-1:0]  signature_value,
	output logic              last_word
);

	localparam int KW = (ACTIVE > 1) ? $clog2(ACTIVE) : 1;
	localparam logic [KW-1:0] K_LAST = KW'(ACTIVE - 1);

	// modulus, zero kept as one
	logic [VAL_W-1:0] mod_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q <= RESET_MODULUS;
		end else if (cfg_we) begin
			mod_q <= (cfg_wdata == '0) ? VAL_W'(1) : cfg_wdata;
		end
	end

	// coefficient tables
	logic [COEF_W-1:0] mult_mem [ACTIVE];
	logic [COEF_W-1:0] add_mem  [ACTIVE];
	logic              idx_ok;

	assign idx_ok = ({1'b0, hash_index} < (IDX_W+1)'(ACTIVE));

	always_ff @(posedge clk) begin
		if (cmd.tbl_wr && idx_ok) begin
			mult_mem[hash_index[KW-1:0]] <= coeff_a;
			add_mem[hash_index[KW-1:0]]  <= coeff_b;
		end
	end

	// element and issue counter
	logic [VAL_W-1:0] x_q;
	logic [KW-1:0]    k_q;

	always_ff @(posedge clk) begin
		if (cmd.elem_start) begin
			x_q <= element_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= '0;
		end else if (cmd.elem_start) begin
			k_q <= '0;
		end else if (cmd.issue_en) begin
			k_q <= (k_q == K_LAST) ? '0 : k_q + KW'(1);
		end
	end

	// s1: table read, s2: multiply-add
	logic              valid_s1, valid_s2;
	logic [KW-1:0]     k_s1, k_s2;
	logic [COEF_W-1:0] a_s1, b_s1;
	logic [PROD_W-1:0] prod_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= cmd.issue_en;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		k_s1    <= k_q;
		a_s1    <= mult_mem[k_q];
		b_s1    <= add_mem[k_q];
		k_s2    <= k_s1;
		prod_s2 <= PROD_W'(a_s1) * PROD_W'(x_q) + PROD_W'(b_s1);
	end

	// modulo pipe
	logic             vld_m, mod_busy;
	logic [VAL_W-1:0] rem_m;
	logic [KW-1:0]    k_m;

	mhs_mod_pipe #(
		.TAG_W(KW)
	) u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s2),
		.dividend  (prod_s2),
		.modulus   (mod_q),
		.tag       (k_s2),
		.out_valid (vld_m),
		.remainder (rem_m),
		.out_tag   (k_m),
		.busy      (mod_busy)
	);

	// running minima, one shared read port for update and readout
	logic [VAL_W-1:0] min_mem [ACTIVE];
	logic [VAL_W-1:0] min_rd_q;
	logic [ACTIVE-1:0] minv_q;
	logic             valid_c1;
	logic [VAL_W-1:0] h_c1;
	logic [KW-1:0]    k_c1;
	logic             upd;
	logic [KW-1:0]    out_cnt_q, out_cnt_nxt, out_addr, rd_addr;

	assign out_cnt_nxt = status.out_last ? '0 : out_cnt_q + KW'(1);
	assign out_addr    = cmd.out_ld ? out_cnt_nxt : out_cnt_q;
	assign rd_addr     = cmd.out_rd ? out_addr : k_m;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_c1 <= 1'b0;
		end else begin
			valid_c1 <= vld_m;
		end
	end

	always_ff @(posedge clk) begin
		h_c1 <= rem_m + VAL_W'(1);
		k_c1 <= k_m;
		if (vld_m || cmd.out_rd) begin
			min_rd_q <= min_mem[rd_addr];
		end
	end

	assign upd = !minv_q[k_c1] || (h_c1 < min_rd_q);

	always_ff @(posedge clk) begin
		if (valid_c1 && upd) begin
			min_mem[k_c1] <= h_c1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			minv_q <= '0;
		end else if (cmd.clear_min) begin
			minv_q <= '0;
		end else if (valid_c1 && upd) begin
			minv_q[k_c1] <= 1'b1;
		end
	end

	// output word register
	logic             out_valid_q;
	logic [IDX_W-1:0] sig_idx_q;
	logic [VAL_W-1:0] sig_val_q;
	logic             last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_cnt_q   <= '0;
		end else begin
			if (cmd.out_ld) begin
				out_valid_q <= 1'b1;
				out_cnt_q   <= out_cnt_nxt;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_ld) begin
			sig_idx_q <= IDX_W'(out_cnt_q);
			sig_val_q <= minv_q[out_cnt_q] ? min_rd_q : '0;
			last_q    <= status.out_last;
		end
	end

	assign out_valid       = out_valid_q;
	assign signature_index = sig_idx_q;
	assign signature_value = sig_val_q;
	assign last_word       = last_q;

	assign status.issue_last = (k_q == K_LAST);
	assign status.pipe_busy  = valid_s1 | valid_s2 | mod_busy | valid_c1;
	assign status.out_free   = !out_valid_q || !out_stall;
	assign status.out_last   = (out_cnt_q == K_LAST);

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_ld |-> (!out_valid_q || !out_stall))
		else $error("output word overwritten before transfer");

	a_start_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.elem_start |-> !status.pipe_busy)
		else $error("element started while pipe still busy");

	a_port_share: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_rd |-> !vld_m)
		else $error("readout clashes with minimum update on read port");

endmodule

// ===== rtl/mhs_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhs_ctrl
// sequencer: accept, hash issue, pipe drain, signature readout
// ----------------------------------------------------------------------------
module mhs_ctrl import mhs_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_stall,
	input  logic  mode,
	input  logic  last_element,
	input  stat_t status,
	output cmd_t  cmd
);

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_ISSUE  = 5'b00010,
		S_DRAIN  = 5'b00100,
		S_OUT_RD = 5'b01000,
		S_OUT_LD = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic   last_q;
	logic   accept;

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;

	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		cmd.tbl_wr    = accept && (mode == MODE_LOAD);
		cmd.elem_start = accept && (mode == MODE_ELEM);
		unique case (state_q)
			S_IDLE: begin
				if (cmd.elem_start) state_d = S_ISSUE;
			end
			S_ISSUE: begin
				cmd.issue_en = 1'b1;
				if (status.issue_last) state_d = S_DRAIN;
			end
			S_DRAIN: begin
				if (!status.pipe_busy) state_d = last_q ? S_OUT_RD : S_IDLE;
			end
			S_OUT_RD: begin
				cmd.out_rd = 1'b1;
				state_d    = S_OUT_LD;
			end
			S_OUT_LD: begin
				if (status.out_free) begin
					cmd.out_ld = 1'b1;
					if (status.out_last) begin
						cmd.clear_min = 1'b1;
						state_d       = S_IDLE;
					end else begin
						cmd.out_rd = 1'b1;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			last_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.elem_start) last_q <= last_element;
		end
	end

endmodule

// ===== rtl/minhash_signature_engine.sv =====
// flow: after an element transfer, ACTIVE = min(NUM_HASHES, 64) hashes are issued, one hash
// per cycle, then the 53-stage modulo pipe drains before the next input is taken; a last
// element adds the signature readout (one word per cycle without output stall);
// load items do not leave the idle state
// reset: arst_n clears control state, valid bits of the minima and sets modulus to 1000003;
// coefficient tables and minima memory hold no defined value until written
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// minhash_signature_engine
// minhash signature over a set of 32-bit elements with ((a*x+b) mod p)+1 hashes
// ----------------------------------------------------------------------------
module minhash_signature_engine import mhs_pkg::*; #(
	parameter int NUM_HASHES = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	// configuration
	input  logic              cfg_we,
	input  logic [VAL_W-1:0]  cfg_wdata,
	// input items
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              mode,
	input  logic [IDX_W-1:0]  hash_index,
	input  logic [COEF_W-1:0] coeff_a,
	input  logic [COEF_W-1:0] coeff_b,
	input  logic [VAL_W-1:0]  element_value,
	input  logic              last_element,
	// signature words
	output logic              out_valid,
	input  logic              out_stall,
	output logic [IDX_W-1:0]  signature_index,
	output logic [VAL_W-1:0]  signature_value,
	output logic              last_word
);

	// hash functions beyond the table depth are inactive
	localparam int ACTIVE = (NUM_HASHES < TABLE_DEPTH) ? NUM_HASHES : TABLE_DEPTH;

	cmd_t  cmd;
	stat_t status;

	// sequencer: takes one item at a time, in_stall high outside idle
	mhs_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.mode         (mode),
		.last_element (last_element),
		.status       (status),
		.cmd          (cmd)
	);

	// tables, hash pipe, minima and the registered output word
	mhs_datapath #(
		.ACTIVE(ACTIVE)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.hash_index      (hash_index),
		.coeff_a         (coeff_a),
		.coeff_b         (coeff_b),
		.element_value   (element_value),
		.out_stall       (out_stall),
		.out_valid       (out_valid),
		.signature_index (signature_index),
		.signature_value (signature_value),
		.last_word       (last_word)
	);

endmodule

// ===== dv/mhs_sig_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhs_sig_checker
// watches the config, element and signature channels of the minhash engine,
// predicts every signature word and compares it field by field
// ----------------------------------------------------------------------------
module mhs_sig_checker import mhs_pkg::*; #(
	parameter int NUM_HASHES = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [VAL_W-1:0]  cfg_wdata,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic              mode,
	input  logic [IDX_W-1:0]  hash_index,
	input  logic [COEF_W-1:0] coeff_a,
	input  logic [COEF_W-1:0] coeff_b,
	input  logic [VAL_W-1:0]  element_value,
	input  logic              last_element,
	input  logic              out_valid,
	input  logic              out_stall,
	input  logic [IDX_W-1:0]  signature_index,
	input  logic [VAL_W-1:0]  signature_value,
	input  logic              last_word,
	output int                mismatches,
	output int                words_due
);

	localparam int ACTIVE = (NUM_HASHES < TABLE_DEPTH) ? NUM_HASHES : TABLE_DEPTH;

	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic [VAL_W-1:0] value;
		logic             last;
	} sig_word_t;

	logic [COEF_W-1:0] mult_coef [TABLE_DEPTH];
	logic [COEF_W-1:0] add_coef  [TABLE_DEPTH];
	logic [VAL_W-1:0]  min_hash  [TABLE_DEPTH];
	logic              min_set   [TABLE_DEPTH];
	logic [VAL_W-1:0]  modulus_now;
	sig_word_t         sig_due [$];
	int                errors_seen;

	// ((a*x+b) mod p)+1, a modulus of zero acts as one
	function automatic logic [VAL_W-1:0] universal_hash(input logic [COEF_W-1:0] a,
			input logic [COEF_W-1:0] b, input logic [VAL_W-1:0] x,
			input logic [VAL_W-1:0] p);
		logic [63:0] prod;
		logic [63:0] p_eff;
		logic [63:0] rem;
		p_eff = (p == '0) ? 64'd1 : {32'd0, p};
		prod  = {44'd0, a} * {32'd0, x} + {44'd0, b};
		rem   = (prod % p_eff) + 64'd1;
		return rem[VAL_W-1:0];
	endfunction

	task automatic fold_element(input logic [VAL_W-1:0] x, input logic last);
		logic [VAL_W-1:0] h;
		sig_word_t        w;
		for (int k = 0; k < ACTIVE; k++) begin
			h = universal_hash(mult_coef[k], add_coef[k], x, modulus_now);
			if (!min_set[k] || h < min_hash[k]) begin
				min_hash[k] = h;
				min_set[k]  = 1'b1;
			end
		end
		if (last) begin
			for (int k = 0; k < ACTIVE; k++) begin
				w.idx   = IDX_W'(k);
				w.value = min_set[k] ? min_hash[k] : '0;
				w.last  = (k == ACTIVE - 1);
				sig_due = {sig_due, w};
				min_set[k] = 1'b0;
			end
		end
	endtask

	task automatic check_word();
		sig_word_t want;
		if (sig_due.size() == 0) begin
			errors_seen++;
			$display("%0t: unexpected signature word, expected none, actual index %0d value %0h last %0b",
				$time, signature_index, signature_value, last_word);
		end else begin
			want = sig_due.pop_front();
			if (signature_index !== want.idx) begin
				errors_seen++;
				$display("%0t: signature_index expected %0d actual %0d",
					$time, want.idx, signature_index);
			end
			if (signature_value !== want.value) begin
				errors_seen++;
				$display("%0t: signature_value (index %0d) expected %0h actual %0h",
					$time, want.idx, want.value, signature_value);
			end
			if (last_word !== want.last) begin
				errors_seen++;
				$display("%0t: last_word (index %0d) expected %0b actual %0b",
					$time, want.idx, want.last, last_word);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_now = RESET_MODULUS;
			for (int k = 0; k < TABLE_DEPTH; k++)
				min_set[k] = 1'b0;
			sig_due.delete();
			errors_seen = 0;
		end else begin
			if (out_valid && !out_stall)
				check_word();
			if (in_valid && !in_stall) begin
				if (mode == MODE_LOAD) begin
					// loads beyond the active count are dropped
					if (hash_index < ACTIVE) begin
						mult_coef[hash_index] = coeff_a;
						add_coef[hash_index]  = coeff_b;
					end
				end else begin
					fold_element(element_value, last_element);
				end
			end
			if (cfg_we)
				modulus_now = cfg_wdata;
		end
		mismatches <= errors_seen;
		words_due  <= sig_due.size();
	end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// minhash signature engine: coefficient loads, element sets and modulus
// changes with random idling on both channels, checked word by word
// ----------------------------------------------------------------------------
module tb;
	import mhs_pkg::*;

	localparam int NUM_HASHES   = 64;
	// long enough for one element and a full unstalled readout to finish
	localparam int DRAIN_CYCLES = 220;
	// longest quiet stretch in a correct run is a drain plus a long gap and
	// one element, well below this
	localparam int QUIET_LIMIT  = 4000;
	localparam int RANDOM_ITEMS = 50;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic [VAL_W-1:0]  cfg_wdata = '0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic              mode = MODE_LOAD;
	logic [IDX_W-1:0]  hash_index = '0;
	logic [COEF_W-1:0] coeff_a = '0;
	logic [COEF_W-1:0] coeff_b = '0;
	logic [VAL_W-1:0]  element_value = '0;
	logic              last_element = 1'b0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [IDX_W-1:0]  signature_index;
	logic [VAL_W-1:0]  signature_value;
	logic              last_word;

	int  mismatches;
	int  words_due;
	// sender idling switched off for whole sets now and then
	bit  no_idle = 1'b0;
	int  stall_run = 0;
	int  calm_run = 0;
	int  quiet_cycles = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	minhash_signature_engine #(
		.NUM_HASHES(NUM_HASHES)
	) dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.mode            (mode),
		.hash_index      (hash_index),
		.coeff_a         (coeff_a),
		.coeff_b         (coeff_b),
		.element_value   (element_value),
		.last_element    (last_element),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.signature_index (signature_index),
		.signature_value (signature_value),
		.last_word       (last_word)
	);

	mhs_sig_checker #(
		.NUM_HASHES(NUM_HASHES)
	) checker_i (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.mode            (mode),
		.hash_index      (hash_index),
		.coeff_a         (coeff_a),
		.coeff_b         (coeff_b),
		.element_value   (element_value),
		.last_element    (last_element),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.signature_index (signature_index),
		.signature_value (signature_value),
		.last_word       (last_word),
		.mismatches      (mismatches),
		.words_due       (words_due)
	);

	// gap length: mostly short, sometimes medium, rarely long
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 3);
		else if (r < 95)
			return $urandom_range(4, 10);
		else
			return $urandom_range(20, 40);
	endfunction

	// element values lean on the extremes and on small numbers
	function automatic logic [VAL_W-1:0] pick_element();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return $urandom_range(0, 255);
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [VAL_W-1:0] pick_modulus();
		case ($urandom_range(0, 6))
			0: return 32'hFFFF_FFFF;
			1: return 32'd2;
			2: return 32'hFFFF_FFFB;         // largest 32-bit prime
			3: return $urandom_range(2, 1000);
			4: return RESET_MODULUS;
			default: return $urandom() | 32'd2;
		endcase
	endfunction

	// signature channel back-pressure: calm stretches, short and long stalls
	always @(posedge clk) begin
		if (calm_run > 0) begin
			calm_run  <= calm_run - 1;
			out_stall <= 1'b0;
		end else if (stall_run > 0) begin
			stall_run <= stall_run - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
			case ($urandom_range(0, 19))
				0:          calm_run  <= $urandom_range(50, 300);
				1, 2, 3, 4: stall_run <= idle_len();
				default: ;
			endcase
		end
	end

	// watchdog: too long without any transfer on either channel ends the run
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("tb: errors");
				$finish;
			end
		end
	end

	// one item on the element channel; returns at the edge of its transfer with
	// valid still high, so a back-to-back item only swaps the payload
	task automatic send_item(input logic item_mode, input logic [IDX_W-1:0] idx,
			input logic [COEF_W-1:0] a, input logic [COEF_W-1:0] b,
			input logic [VAL_W-1:0] x, input logic last);
		int gap;
		gap = (no_idle || $urandom_range(0, 1) == 0) ? 0 : idle_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		mode          <= item_mode;
		hash_index    <= idx;
		coeff_a       <= a;
		coeff_b       <= b;
		element_value <= x;
		last_element  <= last;
		in_valid      <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic load_pair(input logic [IDX_W-1:0] idx, input logic [COEF_W-1:0] a,
			input logic [COEF_W-1:0] b, input logic junk_last);
		// element field carries noise, it must be ignored on a load
		send_item(MODE_LOAD, idx, a, b, $urandom(), junk_last);
	endtask

	task automatic add_element(input logic [VAL_W-1:0] x, input logic last);
		send_item(MODE_ELEM, IDX_W'($urandom()), COEF_W'($urandom()),
			COEF_W'($urandom()), x, last);
	endtask

	// stop sending and let every signature word arrive, then the pipe drain
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (words_due != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_modulus(input logic [VAL_W-1:0] value);
		settle();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	initial begin
		int items;
		int n_loads;
		int n_elems;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill every coefficient pair before any element, with the extreme
		// pairs on the first and last entries
		for (int k = 0; k < NUM_HASHES; k++) begin
			case (k)
				0:              load_pair(IDX_W'(k), '0, '0, 1'b0);
				1:              load_pair(IDX_W'(k), '1, '0, 1'b0);
				2:              load_pair(IDX_W'(k), '0, '1, 1'b0);
				NUM_HASHES - 1: load_pair(IDX_W'(k), '1, '1, 1'b0);
				default:        load_pair(IDX_W'(k), COEF_W'($urandom()),
						COEF_W'($urandom()), 1'b0);
			endcase
		end

		// reset modulus: element extremes in one set, then a one-element set
		add_element('0, 1'b0);
		add_element('1, 1'b0);
		add_element(32'd12345, 1'b1);
		add_element('1, 1'b1);
		// a load flagged last inside a set must not close it
		add_element(32'd7, 1'b0);
		load_pair('0, '0, '0, 1'b1);
		load_pair(IDX_W'(NUM_HASHES - 1), '1, '1, 1'b1);
		add_element(32'd1, 1'b1);

		// modulus zero and one both collapse every hash to one
		write_modulus('0);
		add_element($urandom(), 1'b0);
		add_element('1, 1'b1);
		write_modulus(32'd1);
		add_element($urandom(), 1'b1);
		// smallest and largest moduli, largest product on the last entry
		write_modulus(32'd2);
		add_element('1, 1'b0);
		add_element($urandom(), 1'b1);
		write_modulus('1);
		add_element('1, 1'b0);
		add_element(32'd3, 1'b1);
		write_modulus(RESET_MODULUS);

		// random sets: zero to four coefficient reloads then one to several elements,
		// with occasional modulus changes and full pauses between sets
		items = 0;
		while (items < RANDOM_ITEMS) begin
			if ($urandom_range(0, 3) == 0)
				write_modulus(pick_modulus());
			else if ($urandom_range(0, 7) == 0)
				settle();
			no_idle = ($urandom_range(0, 4) == 0);
			n_loads = $urandom_range(0, 4);
			for (int i = 0; i < n_loads; i++) begin
				load_pair(IDX_W'($urandom_range(0, NUM_HASHES - 1)), COEF_W'($urandom()),
					COEF_W'($urandom()), 1'($urandom_range(0, 1)));
				items++;
			end
			n_elems = ($urandom_range(0, 5) == 0) ? $urandom_range(6, 12) : $urandom_range(1, 5);
			for (int i = 0; i < n_elems; i++) begin
				add_element(pick_element(), i == n_elems - 1);
				items++;
			end
		end
		no_idle = 1'b0;

		settle();
		if (mismatches == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule

// ===== minhash_signature_engine.f =====
rtl/mhs_pkg.sv
rtl/mhs_mod_pipe.sv
rtl/mhs_datapath.sv
rtl/mhs_ctrl.sv
rtl/minhash_signature_engine.sv
dv/mhs_sig_checker.sv
dv/tb.sv
